// ===== sv/clfr_pkg.sv =====
// Package for the CRC-8 checked line frame receiver: types, codes and CRC helper.
package clfr_pkg;

	localparam int LINE_MAX_DEF = 511;
	localparam int POS_W        = 9;
	localparam int WIDE_POS_W   = 10;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_G     = 8'h67;

	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_POS  = 2'd1,
		PH_NEG  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KW_IDLE = 3'd0,
		KW_P    = 3'd1,
		KW_PI   = 3'd2,
		KW_PIN  = 3'd3,
		KW_PING = 3'd4,
		KW_PO   = 3'd5,
		KW_PON  = 3'd6,
		KW_PONG = 3'd7
	} kw_t;

	typedef enum logic [2:0] {
		VERDICT_NONE     = 3'd0,
		VERDICT_PING     = 3'd1,
		VERDICT_PONG     = 3'd2,
		VERDICT_FRAME_OK = 3'd3,
		VERDICT_BAD_CRC  = 3'd4,
		VERDICT_UNPARSED = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} rx_item_t;

	typedef struct packed {
		logic               byte_kept;
		logic [POS_W-1:0]   line_index;
		logic               line_end;
		logic [2:0]         verdict;
		logic signed [31:0] frame_id;
		logic [POS_W-1:0]   content_start;
		logic [POS_W-1:0]   content_len;
		logic               port_locked;
	} res_item_t;

	// CRC-8/SMBUS, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/clfr_num_parser.sv =====
// Next-state logic of one running signed decimal parser.
module clfr_num_parser
	import clfr_pkg::*;
(
	input  logic [31:0] acc,
	input  phase_t      phase,
	input  logic [7:0]  c,
	output logic [31:0] acc_nx,
	output phase_t      phase_nx
);

	logic        digit;
	logic [31:0] d;
	logic [31:0] acc_x10;

	assign digit   = (c >= CH_ZERO) && (c <= CH_NINE);
	assign d       = {24'd0, c - CH_ZERO};
	assign acc_x10 = (acc << 3) + (acc << 1);

	always_comb begin
		acc_nx   = acc;
		phase_nx = phase;
		unique case (phase)
			PH_SKIP: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
					phase_nx = PH_SKIP;
				end else if (c == CH_PLUS) begin
					phase_nx = PH_POS;
				end else if (c == CH_MINUS) begin
					phase_nx = PH_NEG;
				end else if (digit) begin
					acc_nx   = d;
					phase_nx = PH_POS;
				end else begin
					phase_nx = PH_DONE;
				end
			end
			PH_POS: begin
				if (digit) begin
					acc_nx = acc_x10 + d;
				end else begin
					phase_nx = PH_DONE;
				end
			end
			PH_NEG: begin
				if (digit) begin
					acc_nx = acc_x10 - d;
				end else begin
					phase_nx = PH_DONE;
				end
			end
			PH_DONE: begin
				phase_nx = PH_DONE;
			end
		endcase
	end

endmodule

// ===== sv/clfr_line_core.sv =====
// Line state registers and per-byte result logic: CRC, keyword match, parsers, verdict.
module clfr_line_core
	import clfr_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  rx_item_t  item,
	output res_item_t res
);

	localparam int LEN_W = $clog2(LINE_MAX + 1);

	logic [LEN_W-1:0] len_q, cur_len, nx_len;
	logic             text_end_q, cur_text_end, nx_text_end;
	logic [7:0]       crc_q, cur_crc, nx_crc;
	logic [7:0]       crc_bar_q, cur_crc_bar, nx_crc_bar;
	logic [LEN_W-1:0] colon_pos_q, cur_colon_pos, nx_colon_pos;
	logic             colon_seen_q, cur_colon_seen, nx_colon_seen;
	logic [LEN_W-1:0] bar_pos_q, cur_bar_pos, nx_bar_pos;
	logic             bar_seen_q, cur_bar_seen, nx_bar_seen;
	logic [31:0]      id_acc_q, cur_id_acc, nx_id_acc;
	phase_t           id_ph_q, cur_id_ph, nx_id_ph;
	logic [31:0]      chk_acc_q, cur_chk_acc, nx_chk_acc;
	phase_t           chk_ph_q, cur_chk_ph, nx_chk_ph;
	kw_t              kw_q, cur_kw, nx_kw;
	logic             lock_q, cur_lock, nx_lock;

	logic [31:0] id_acc_p, chk_acc_p;
	phase_t      id_ph_p, chk_ph_p;
	logic [7:0]  c;
	logic [WIDE_POS_W-1:0] idx_w, cstart_w, clen_w;

	assign c = item.rx_byte;

	// restart clears the line and the lock before this byte is looked at
	always_comb begin
		if (item.restart) begin
			cur_len        = '0;
			cur_text_end   = 1'b0;
			cur_crc        = '0;
			cur_crc_bar    = '0;
			cur_colon_pos  = '0;
			cur_colon_seen = 1'b0;
			cur_bar_pos    = '0;
			cur_bar_seen   = 1'b0;
			cur_id_acc     = '0;
			cur_id_ph      = PH_SKIP;
			cur_chk_acc    = '0;
			cur_chk_ph     = PH_SKIP;
			cur_kw         = KW_IDLE;
			cur_lock       = 1'b0;
		end else begin
			cur_len        = len_q;
			cur_text_end   = text_end_q;
			cur_crc        = crc_q;
			cur_crc_bar    = crc_bar_q;
			cur_colon_pos  = colon_pos_q;
			cur_colon_seen = colon_seen_q;
			cur_bar_pos    = bar_pos_q;
			cur_bar_seen   = bar_seen_q;
			cur_id_acc     = id_acc_q;
			cur_id_ph      = id_ph_q;
			cur_chk_acc    = chk_acc_q;
			cur_chk_ph     = chk_ph_q;
			cur_kw         = kw_q;
			cur_lock       = lock_q;
		end
	end

	clfr_num_parser u_id_parser (
		.acc      (cur_id_acc),
		.phase    (cur_id_ph),
		.c        (c),
		.acc_nx   (id_acc_p),
		.phase_nx (id_ph_p)
	);

	clfr_num_parser u_chk_parser (
		.acc      (cur_chk_acc),
		.phase    (cur_chk_ph),
		.c        (c),
		.acc_nx   (chk_acc_p),
		.phase_nx (chk_ph_p)
	);

	assign idx_w    = WIDE_POS_W'(cur_len);
	assign cstart_w = WIDE_POS_W'(cur_colon_pos) + WIDE_POS_W'(1);
	assign clen_w   = WIDE_POS_W'(cur_bar_pos) - WIDE_POS_W'(cur_colon_pos) - WIDE_POS_W'(1);

	always_comb begin
		nx_len        = cur_len;
		nx_text_end   = cur_text_end;
		nx_crc        = cur_crc;
		nx_crc_bar    = cur_crc_bar;
		nx_colon_pos  = cur_colon_pos;
		nx_colon_seen = cur_colon_seen;
		nx_bar_pos    = cur_bar_pos;
		nx_bar_seen   = cur_bar_seen;
		nx_id_acc     = cur_id_acc;
		nx_id_ph      = cur_id_ph;
		nx_chk_acc    = cur_chk_acc;
		nx_chk_ph     = cur_chk_ph;
		nx_kw         = cur_kw;
		nx_lock       = cur_lock;

		res               = '0;

		if (c == CH_LF || c == CH_CR) begin
			if (cur_len != '0) begin
				res.line_end = 1'b1;
				if (cur_kw == KW_PING) begin
					res.verdict = VERDICT_PING;
					nx_lock     = 1'b1;
				end else if (cur_kw == KW_PONG) begin
					res.verdict = VERDICT_PONG;
				end else if (cur_colon_seen && cur_bar_seen && (cur_bar_pos > cur_colon_pos)) begin
					if (cur_crc_bar == cur_chk_acc[7:0]) begin
						res.verdict = VERDICT_FRAME_OK;
						nx_lock     = 1'b1;
					end else begin
						res.verdict = VERDICT_BAD_CRC;
					end
					res.frame_id      = cur_id_acc;
					res.content_start = cstart_w[POS_W-1:0];
					res.content_len   = clen_w[POS_W-1:0];
				end else begin
					res.verdict = VERDICT_UNPARSED;
				end
				nx_len        = '0;
				nx_text_end   = 1'b0;
				nx_crc        = '0;
				nx_crc_bar    = '0;
				nx_colon_pos  = '0;
				nx_colon_seen = 1'b0;
				nx_bar_pos    = '0;
				nx_bar_seen   = 1'b0;
				nx_id_acc     = '0;
				nx_id_ph      = PH_SKIP;
				nx_chk_acc    = '0;
				nx_chk_ph     = PH_SKIP;
				nx_kw         = KW_IDLE;
			end
		end else if (cur_len < LEN_W'(LINE_MAX)) begin
			res.byte_kept  = 1'b1;
			res.line_index = idx_w[POS_W-1:0];
			if (c == CH_NUL) begin
				nx_text_end = 1'b1;
			end
			if (!cur_text_end && c != CH_NUL) begin
				unique case (cur_kw)
					KW_IDLE: nx_kw = (cur_len == '0 && c == CH_P) ? KW_P : KW_IDLE;
					KW_P:    nx_kw = (c == CH_I) ? KW_PI : ((c == CH_O) ? KW_PO : KW_IDLE);
					KW_PI:   nx_kw = (c == CH_N) ? KW_PIN : KW_IDLE;
					KW_PIN:  nx_kw = (c == CH_G) ? KW_PING : KW_IDLE;
					KW_PING: nx_kw = KW_IDLE;
					KW_PO:   nx_kw = (c == CH_N) ? KW_PON : KW_IDLE;
					KW_PON:  nx_kw = (c == CH_G) ? KW_PONG : KW_IDLE;
					KW_PONG: nx_kw = KW_PONG;
				endcase
				if (!cur_colon_seen) begin
					if (c == CH_COLON) begin
						nx_colon_seen = 1'b1;
						nx_colon_pos  = cur_len;
					end
					nx_id_acc = id_acc_p;
					nx_id_ph  = id_ph_p;
				end
				// each bar restarts the check number and snapshots the CRC
				if (c == CH_BAR) begin
					nx_bar_seen = 1'b1;
					nx_bar_pos  = cur_len;
					nx_crc_bar  = cur_crc;
					nx_chk_acc  = '0;
					nx_chk_ph   = PH_SKIP;
				end else if (cur_bar_seen) begin
					nx_chk_acc = chk_acc_p;
					nx_chk_ph  = chk_ph_p;
				end
				nx_crc = crc8_byte(cur_crc, c);
			end
			nx_len = cur_len + LEN_W'(1);
		end

		res.port_locked = nx_lock;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			text_end_q   <= 1'b0;
			crc_q        <= '0;
			crc_bar_q    <= '0;
			colon_pos_q  <= '0;
			colon_seen_q <= 1'b0;
			bar_pos_q    <= '0;
			bar_seen_q   <= 1'b0;
			id_acc_q     <= '0;
			id_ph_q      <= PH_SKIP;
			chk_acc_q    <= '0;
			chk_ph_q     <= PH_SKIP;
			kw_q         <= KW_IDLE;
			lock_q       <= 1'b0;
		end else if (take) begin
			len_q        <= nx_len;
			text_end_q   <= nx_text_end;
			crc_q        <= nx_crc;
			crc_bar_q    <= nx_crc_bar;
			colon_pos_q  <= nx_colon_pos;
			colon_seen_q <= nx_colon_seen;
			bar_pos_q    <= nx_bar_pos;
			bar_seen_q   <= nx_bar_seen;
			id_acc_q     <= nx_id_acc;
			id_ph_q      <= nx_id_ph;
			chk_acc_q    <= nx_chk_acc;
			chk_ph_q     <= nx_chk_ph;
			kw_q         <= nx_kw;
			lock_q       <= nx_lock;
		end
	end

endmodule

// ===== sv/crc8_line_frame_receiver_top.sv =====
// Top level of the CRC-8 checked line frame receiver: input register, line core, result register.
// Timing: a byte passes the input register, then its result is held in the result register and
//   offered; the line state is updated as the byte leaves the input register.
// Throughput: one byte per cycle; stall on the result side backs up through both registers.
// Reset: arst_n clears all line state, the port lock and both valid flags at once.
module crc8_line_frame_receiver_top
	import clfr_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	output logic      rx_stall,
	input  rx_item_t  rx_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	logic      valid_s1;
	rx_item_t  item_s1;
	logic      valid_s2;
	res_item_t item_s2;
	res_item_t core_res;
	logic      adv;
	logic      take;

	assign adv      = !valid_s2 || !res_stall;
	assign take     = valid_s1 && adv;
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			item_s1 <= rx_item;
		end
	end

	clfr_line_core #(
		.LINE_MAX (LINE_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s2 <= core_res;
		end
	end

	assign res_valid = valid_s2;
	assign res_item  = item_s2;

endmodule

// ===== sv/clfr_checker.sv =====
// Port-level checker for the line frame receiver, bound to the top level.
module clfr_checker
	import clfr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// a stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_verdict_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.line_end |-> res_item.verdict == VERDICT_NONE)
		else $error("verdict without line end");

	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.verdict != VERDICT_FRAME_OK && res_item.verdict != VERDICT_BAD_CRC
		|-> res_item.frame_id == 0 && res_item.content_start == '0
		    && res_item.content_len == '0)
		else $error("frame fields set without a frame verdict");

	a_kept_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.byte_kept |-> !res_item.line_end)
		else $error("byte kept and line ended together");

	a_lock_on_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.verdict == VERDICT_PING || res_item.verdict == VERDICT_FRAME_OK)
		|-> res_item.port_locked)
		else $error("port not locked after ping or good frame");

endmodule

bind crc8_line_frame_receiver_top clfr_checker u_clfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

// ===== dv/crc8_line_frame_receiver_top_tb.sv =====
// Self-checking testbench for the CRC-8 checked line frame receiver top level.
`timescale 1ns / 1ps

module crc8_line_frame_receiver_top_tb;
	import clfr_pkg::*;

	localparam int LINE_LIMIT = LINE_MAX_DEF;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		rx_item_t  item;
		bit        typed;
		res_item_t want;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      rx_valid  = 1'b0;
	logic      rx_stall;
	rx_item_t  rx_item   = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	crc8_line_frame_receiver_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_item  (rx_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	always #1 clk = ~clk;

	// line parser state mirrored by the predictor
	logic [9:0]  ln_len;
	logic        txt_end;
	logic [7:0]  crc_run;
	logic [7:0]  crc_bar;
	logic [9:0]  colon_pos;
	logic        colon_hit;
	logic [9:0]  bar_pos;
	logic        bar_hit;
	logic [31:0] id_acc;
	phase_t      id_ph;
	logic [31:0] chk_acc;
	phase_t      chk_ph;
	kw_t         kw;
	logic        locked;

	res_item_t   line_results_q[$];
	logic [7:0]  line_buf[$];
	dir_row_t    dir_tab[$];
	int          gap_pct   = 0;
	int          stall_pct = 0;
	int          bytes_sent = 0;
	int          errors = 0;

	function automatic logic [7:0] crc8_smbus(logic [7:0] crc, logic [7:0] b);
		logic       fb;
		logic [7:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return c;
	endfunction

	function automatic void num_advance(inout logic [31:0] acc, inout phase_t ph,
			input logic [7:0] c);
		logic        is_dig;
		logic [31:0] d;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = {24'd0, c - CH_ZERO};
		case (ph)
			PH_SKIP: begin
				if (!(c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
					if (c == CH_PLUS) ph = PH_POS;
					else if (c == CH_MINUS) ph = PH_NEG;
					else if (is_dig) begin
						acc = d;
						ph = PH_POS;
					end else ph = PH_DONE;
				end
			end
			PH_POS: begin
				if (is_dig) acc = acc * 32'd10 + d;
				else ph = PH_DONE;
			end
			PH_NEG: begin
				if (is_dig) acc = acc * 32'd10 - d;
				else ph = PH_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic kw_t kw_next(kw_t s, logic [7:0] c, logic first);
		case (s)
			KW_IDLE: return (first && c == CH_P) ? KW_P : KW_IDLE;
			KW_P:    return (c == CH_I) ? KW_PI : ((c == CH_O) ? KW_PO : KW_IDLE);
			KW_PI:   return (c == CH_N) ? KW_PIN : KW_IDLE;
			KW_PIN:  return (c == CH_G) ? KW_PING : KW_IDLE;
			KW_PO:   return (c == CH_N) ? KW_PON : KW_IDLE;
			KW_PON:  return (c == CH_G) ? KW_PONG : KW_IDLE;
			KW_PONG: return KW_PONG;
			default: return KW_IDLE;
		endcase
	endfunction

	function automatic void clear_line_state();
		ln_len    = '0;
		txt_end   = 1'b0;
		crc_run   = '0;
		crc_bar   = '0;
		colon_pos = '0;
		colon_hit = 1'b0;
		bar_pos   = '0;
		bar_hit   = 1'b0;
		id_acc    = '0;
		id_ph     = PH_SKIP;
		chk_acc   = '0;
		chk_ph    = PH_SKIP;
		kw        = KW_IDLE;
	endfunction

	function automatic res_item_t predict_byte(rx_item_t it);
		res_item_t  r;
		logic [7:0] c;
		logic [9:0] pos;
		r = '0;
		c = it.rx_byte;
		if (it.restart) begin
			clear_line_state();
			locked = 1'b0;
		end
		if (c == CH_LF || c == CH_CR) begin
			if (ln_len != 0) begin
				r.line_end = 1'b1;
				if (kw == KW_PING) begin
					r.verdict = VERDICT_PING;
					locked = 1'b1;
				end else if (kw == KW_PONG) begin
					r.verdict = VERDICT_PONG;
				end else if (colon_hit && bar_hit && bar_pos > colon_pos) begin
					if (crc_bar == chk_acc[7:0]) begin
						r.verdict = VERDICT_FRAME_OK;
						locked = 1'b1;
					end else begin
						r.verdict = VERDICT_BAD_CRC;
					end
					r.frame_id = id_acc;
					pos = colon_pos + 10'd1;
					r.content_start = pos[POS_W-1:0];
					pos = bar_pos - colon_pos - 10'd1;
					r.content_len = pos[POS_W-1:0];
				end else begin
					r.verdict = VERDICT_UNPARSED;
				end
				clear_line_state();
			end
		end else if (ln_len < LINE_LIMIT) begin
			r.byte_kept = 1'b1;
			r.line_index = ln_len[POS_W-1:0];
			if (c == CH_NUL) txt_end = 1'b1;
			if (!txt_end) begin
				kw = kw_next(kw, c, ln_len == 0);
				if (!colon_hit) begin
					if (c == CH_COLON) begin
						colon_hit = 1'b1;
						colon_pos = ln_len;
					end
					num_advance(id_acc, id_ph, c);
				end
				if (c == CH_BAR) begin
					bar_hit = 1'b1;
					bar_pos = ln_len;
					crc_bar = crc_run;
					chk_acc = '0;
					chk_ph  = PH_SKIP;
				end else if (bar_hit) begin
					num_advance(chk_acc, chk_ph, c);
				end
				crc_run = crc8_smbus(crc_run, c);
			end
			ln_len = ln_len + 10'd1;
		end
		r.port_locked = locked;
		return r;
	endfunction

	function automatic res_item_t mk_res(logic kept, logic lend, verdict_t v, logic lock);
		res_item_t r;
		r = '0;
		r.byte_kept = kept;
		r.line_end = lend;
		r.verdict = v;
		r.port_locked = lock;
		return r;
	endfunction

	function automatic void add_row(logic [7:0] b, logic rs, bit typed = 1'b0,
			res_item_t want = '0);
		dir_row_t row;
		row.item.rx_byte = b;
		row.item.restart = rs;
		row.typed = typed;
		row.want = want;
		dir_tab.push_back(row);
	endfunction

	// ---- line builders ----

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void put_ws();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) begin
			case ($urandom_range(3))
				0: line_buf.push_back(CH_SPACE);
				1: line_buf.push_back(CH_TAB);
				2: line_buf.push_back(CH_VT);
				default: line_buf.push_back(CH_FF);
			endcase
		end
	endfunction

	// any byte that neither terminates the line nor ends the text
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == CH_CR);
		return b;
	endfunction

	function automatic void build_frame(bit corrupt, int clen);
		logic [31:0] idv;
		logic [7:0]  crc;
		int          chk;
		idv = $urandom;
		put_ws();
		case ($urandom_range(3))
			0: put_text($sformatf("%0d", $signed(idv)));
			1: put_text($sformatf("+%0d", idv));
			2: put_text($sformatf("%0d%0d", idv, $urandom));
			default: put_text($sformatf("%0d", idv[7:0]));
		endcase
		line_buf.push_back(CH_COLON);
		repeat (clen) line_buf.push_back(text_byte());
		crc = '0;
		foreach (line_buf[i]) crc = crc8_smbus(crc, line_buf[i]);
		line_buf.push_back(CH_BAR);
		put_ws();
		chk = corrupt ? int'(crc ^ 8'($urandom_range(1, 255))) : int'(crc);
		// several spellings that are all equal to the check value (the CRC, or a corrupted CRC) modulo 256
		case ($urandom_range(3))
			0: put_text($sformatf("%0d", chk));
			1: put_text($sformatf("+%0d", chk + 256 * $urandom_range(0, 100)));
			2: put_text($sformatf("-%0d", 256 - chk));
			default: put_text($sformatf("%0d", chk + 256 * $urandom_range(1000, 8000000)));
		endcase
		if ($urandom_range(3) == 0) line_buf.push_back("x");
	endfunction

	function automatic void build_broken();
		int idx;
		build_frame(1'b0, $urandom_range(0, 8));
		case ($urandom_range(3))
			0: begin
				idx = $urandom_range(0, line_buf.size() - 1);
				line_buf.insert(idx, CH_NUL);
			end
			1: begin
				// last bar ahead of the first colon
				line_buf.delete();
				put_text($sformatf("%0d|", $urandom_range(0, 999)));
				repeat ($urandom_range(0, 4)) line_buf.push_back(text_byte());
				line_buf.push_back(CH_COLON);
				put_text($sformatf("%0d", $urandom_range(0, 255)));
			end
			2: begin
				idx = -1;
				foreach (line_buf[i]) if (line_buf[i] == CH_BAR) idx = i;
				if (idx >= 0) line_buf.delete(idx);
			end
			default: begin
				idx = -1;
				foreach (line_buf[i]) if (idx < 0 && line_buf[i] == CH_COLON) idx = i;
				if (idx >= 0) line_buf.delete(idx);
			end
		endcase
	endfunction

	// ---- handshake ----

	task automatic send_item(rx_item_t it, bit typed = 1'b0, res_item_t want = '0);
		res_item_t pred;
		while ($urandom_range(99) < gap_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= it;
		do @(posedge clk); while (rx_stall);
		pred = predict_byte(it);
		line_results_q.push_back(typed ? want : pred);
		bytes_sent++;
	endtask

	task automatic send_line(bit noisy);
		rx_item_t it;
		foreach (line_buf[i]) begin
			it.rx_byte = line_buf[i];
			it.restart = noisy ? ($urandom_range(99) < 5) : (i == 0 && $urandom_range(99) < 4);
			send_item(it);
		end
		it.rx_byte = $urandom_range(1) ? CH_LF : CH_CR;
		it.restart = ($urandom_range(99) < 2);
		send_item(it);
	endtask

	task automatic random_line();
		int pick;
		bit noisy;
		pick = $urandom_range(99);
		noisy = 1'b0;
		line_buf.delete();
		if (pick < 38) begin
			build_frame(1'b0, $urandom_range(0, 8));
		end else if (pick < 46) begin
			build_frame(1'b1, $urandom_range(0, 8));
		end else if (pick < 56) begin
			build_broken();
		end else if (pick < 63) begin
			case ($urandom_range(4))
				0: put_text("pin");
				1: put_text("pingg");
				2: put_text("Ping");
				default: put_text("ping");
			endcase
		end else if (pick < 69) begin
			put_text("pong");
			repeat ($urandom_range(0, 6)) line_buf.push_back(text_byte());
		end else if (pick < 76) begin
			// blank line: terminator only
		end else begin
			noisy = 1'b1;
			repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
		end
		send_line(noisy);
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (line_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_idling(idle_mode_t m);
		case (m)
			IDLE_SEND: begin gap_pct = 58; stall_pct = 0; end
			IDLE_RECV: begin gap_pct = 0; stall_pct = 58; end
			IDLE_BOTH: begin gap_pct = 17; stall_pct = 17; end
			default:   begin gap_pct = 0; stall_pct = 0; end
		endcase
	endtask

	always @(posedge clk) res_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (line_results_q.size() == 0) begin
				$error("unexpected result transaction: %p", res_item);
				errors++;
			end else begin
				want = line_results_q.pop_front();
				if (res_item.byte_kept !== want.byte_kept) begin
					$error("byte_kept: expected %0d, got %0d", want.byte_kept, res_item.byte_kept);
					errors++;
				end
				if (res_item.line_index !== want.line_index) begin
					$error("line_index: expected %0d, got %0d", want.line_index,
						res_item.line_index);
					errors++;
				end
				if (res_item.line_end !== want.line_end) begin
					$error("line_end: expected %0d, got %0d", want.line_end, res_item.line_end);
					errors++;
				end
				if (res_item.verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, res_item.verdict);
					errors++;
				end
				if (res_item.frame_id !== want.frame_id) begin
					$error("frame_id: expected %0d, got %0d", $signed(want.frame_id),
						$signed(res_item.frame_id));
					errors++;
				end
				if (res_item.content_start !== want.content_start) begin
					$error("content_start: expected %0d, got %0d", want.content_start,
						res_item.content_start);
					errors++;
				end
				if (res_item.content_len !== want.content_len) begin
					$error("content_len: expected %0d, got %0d", want.content_len,
						res_item.content_len);
					errors++;
				end
				if (res_item.port_locked !== want.port_locked) begin
					$error("port_locked: expected %0d, got %0d", want.port_locked,
						res_item.port_locked);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int quota;
		clear_line_state();
		locked = 1'b0;

		// directed rows: blank line, ping, pong, bar ahead of colon, zero byte, signed id
		add_row(CH_LF, 1'b1, 1'b1, mk_res(1'b0, 1'b0, VERDICT_NONE, 1'b0));
		add_row(CH_P, 1'b0);
		add_row(CH_I, 1'b0);
		add_row(CH_N, 1'b0);
		add_row(CH_G, 1'b0);
		add_row(CH_CR, 1'b0, 1'b1, mk_res(1'b0, 1'b1, VERDICT_PING, 1'b1));
		add_row(CH_P, 1'b0);
		add_row(CH_O, 1'b0);
		add_row(CH_N, 1'b0);
		add_row(CH_G, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(CH_LF, 1'b0, 1'b1, mk_res(1'b0, 1'b1, VERDICT_PONG, 1'b1));
		add_row(CH_BAR, 1'b0);
		add_row(CH_COLON, 1'b0);
		add_row(CH_LF, 1'b0, 1'b1, mk_res(1'b0, 1'b1, VERDICT_UNPARSED, 1'b1));
		add_row(CH_NUL, 1'b1, 1'b1, mk_res(1'b1, 1'b0, VERDICT_NONE, 1'b0));
		add_row(CH_COLON, 1'b0);
		add_row(CH_BAR, 1'b0);
		add_row(CH_CR, 1'b0, 1'b1, mk_res(1'b0, 1'b1, VERDICT_UNPARSED, 1'b0));
		add_row(CH_MINUS, 1'b0);
		add_row("9", 1'b0);
		add_row(CH_COLON, 1'b0);
		add_row(CH_BAR, 1'b0);
		add_row(CH_SPACE, 1'b0);
		add_row(CH_LF, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			// sender holds off until the block has drained
			wait_drained();
			set_idling(idle_mode_t'(ph));
			if (ph == 1) begin
				line_buf.delete();
				build_frame(1'b0, 470);
				send_line(1'b0);
			end
			if (ph == 2) begin
				// overlong line: the tail is dropped
				line_buf.delete();
				repeat (LINE_LIMIT + 4) line_buf.push_back(text_byte());
				send_line(1'b0);
			end
			quota = bytes_sent + 180;
			while (bytes_sent < quota) random_line();
		end

		wait_drained();
		set_idling(IDLE_NONE);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/clfr_pkg.sv
sv/clfr_num_parser.sv
sv/clfr_line_core.sv
sv/crc8_line_frame_receiver_top.sv
sv/clfr_checker.sv
dv/crc8_line_frame_receiver_top_tb.sv
